@@ design/rmd_pkg.sv @@
// shared types, constants and step tables for the ripemd-160 compression block
package rmd_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned Steps = 80;
    localparam int unsigned BlockLen = 16;

    typedef struct packed {
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
        logic [WordW-1:0] c;
        logic [WordW-1:0] d;
        logic [WordW-1:0] e;
    } t_line;

    typedef struct packed {
        logic [6:0] step;
        logic       right;
    } t_step_ctl;

    localparam logic [WordW-1:0] INIT_CV [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0};

    localparam logic [WordW-1:0] LK [5] = '{
        32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'ha953fd4e};
    localparam logic [WordW-1:0] RK [5] = '{
        32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h7a6d76e9, 32'h00000000};

    localparam logic [3:0] LW_IDX [Steps] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
        4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
        4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
        4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
        4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
        4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
        4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13};

    localparam logic [3:0] LW_ROT [Steps] = '{
        4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
        4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
        4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
        4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
        4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
        4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
        4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
        4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
        4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
        4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6};

    localparam logic [3:0] RW_IDX [Steps] = '{
        4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
        4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
        4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
        4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
        4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
        4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
        4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
        4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
        4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
        4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11};

    localparam logic [3:0] RW_ROT [Steps] = '{
        4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
        4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
        4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
        4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
        4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
        4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
        4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
        4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
        4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
        4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11};

    // word slot read by a step of one line; steps past the end read slot zero
    function automatic logic [3:0] word_idx(input logic right, input logic [6:0] step);
        logic [3:0] idx;
        idx = '0;
        if (step < 7'(Steps)) begin
            idx = right ? RW_IDX[step] : LW_IDX[step];
        end
        return idx;
    endfunction

    function automatic logic [3:0] rot_amt(input logic right, input logic [6:0] step);
        logic [3:0] amt;
        amt = '0;
        if (step < 7'(Steps)) begin
            amt = right ? RW_ROT[step] : LW_ROT[step];
        end
        return amt;
    endfunction

    function automatic logic [WordW-1:0] round_k(input logic right, input logic [2:0] rnd);
        logic [WordW-1:0] k;
        k = '0;
        if (rnd < 3'd5) begin
            k = right ? RK[rnd] : LK[rnd];
        end
        return k;
    endfunction

    function automatic logic [WordW-1:0] bool_f(input logic [2:0] sel,
                                               input logic [WordW-1:0] x,
                                               input logic [WordW-1:0] y,
                                               input logic [WordW-1:0] z);
        logic [WordW-1:0] f;
        unique case (sel)
            3'd0:    f = x ^ y ^ z;
            3'd1:    f = (x & y) | (~x & z);
            3'd2:    f = (x | ~y) ^ z;
            3'd3:    f = (x & z) | (y & ~z);
            default: f = x ^ (y | ~z);
        endcase
        return f;
    endfunction

    function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
                                             input logic [4:0] n);
        logic [2*WordW-1:0] dbl;
        dbl = {v, v} << n;
        return dbl[2*WordW-1:WordW];
    endfunction

endpackage

@@ design/rmd_ram.sv @@
// generic ram, one write port and two registered read ports
module rmd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ design/rmd_step.sv @@
// one compression step of either line
module rmd_step (
    input  rmd_pkg::t_line             i_line,
    input  logic [rmd_pkg::WordW-1:0] i_word,
    input  rmd_pkg::t_step_ctl         i_ctl,
    output rmd_pkg::t_line             o_line
);

    logic [2:0]                rnd;
    logic [2:0]                sel;
    logic [rmd_pkg::WordW-1:0] f;
    logic [rmd_pkg::WordW-1:0] sum;
    logic [rmd_pkg::WordW-1:0] t;

    assign rnd = i_ctl.step[6:4];
    assign sel = i_ctl.right ? 3'(3'd4 - rnd) : rnd;
    assign f   = rmd_pkg::bool_f(sel, i_line.b, i_line.c, i_line.d);
    assign sum = i_line.a + f + i_word + rmd_pkg::round_k(i_ctl.right, rnd);
    assign t   = rmd_pkg::rotl(sum, {1'b0, rmd_pkg::rot_amt(i_ctl.right, i_ctl.step)})
                 + i_line.e;

    always_comb begin
        o_line.a = i_line.e;
        o_line.b = t;
        o_line.c = i_line.b;
        o_line.d = rmd_pkg::rotl(i_line.c, 5'd10);
        o_line.e = i_line.d;
    end

endmodule

@@ design/ripemd160_compression.sv @@
// ripemd-160 compression top level: word buffer, step sequencer, chaining value
//
// channel  direction  tdata          tuser          tlast
// s_axis   in         message_word   start_message  end_message
// m_axis   out        digest_word    -              digest_last
//
// words 1..15 of a block are taken one per cycle; after word 16 the block is busy
// in turn: S_LOAD loads both lines, S_COMP runs the 80 steps with both lines
// stepping together through the step units, S_FOLD folds into the chaining value.
// with the end flag the five digest words follow, one per output transaction,
// and a stalled output holds the block. reset loads the initial chaining value.
module ripemd160_compression (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // message_word
    input  logic [0:0]  i_s_axis_tuser,   // start_message
    input  logic        i_s_axis_tlast,   // end_message
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // digest_word
    output logic        o_m_axis_tlast    // digest_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_COMP,
        S_FOLD,
        S_OUT
    } t_state;

    t_state                    r_state;
    logic [3:0]                r_pos;
    logic [6:0]                r_step;
    logic [2:0]                r_out_idx;
    logic                      r_end;
    logic [rmd_pkg::WordW-1:0] r_cv [5];
    rmd_pkg::t_line            r_left;
    rmd_pkg::t_line            r_right;

    logic                      in_acc;
    logic                      out_acc;
    logic [3:0]                wr_addr;
    logic [6:0]                rd_step;
    logic [rmd_pkg::WordW-1:0] word_l;
    logic [rmd_pkg::WordW-1:0] word_r;
    rmd_pkg::t_line            n_left;
    rmd_pkg::t_line            n_right;
    rmd_pkg::t_step_ctl        ctl_l;
    rmd_pkg::t_step_ctl        ctl_r;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign out_acc         = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = r_cv[r_out_idx];
    assign o_m_axis_tlast  = (r_out_idx == 3'd4);

    assign wr_addr = i_s_axis_tuser[0] ? 4'd0 : r_pos;
    assign rd_step = (r_state == S_COMP) ? 7'(r_step + 7'd1) : 7'd0;

    rmd_ram #(
        .WIDTH (rmd_pkg::WordW),
        .DEPTH (rmd_pkg::BlockLen)
    ) u_words (
        .i_clk     (i_clk),
        .i_we      (in_acc),
        .i_waddr   (wr_addr),
        .i_wdata   (i_s_axis_tdata),
        .i_raddr_a (rmd_pkg::word_idx(1'b0, rd_step)),
        .o_rdata_a (word_l),
        .i_raddr_b (rmd_pkg::word_idx(1'b1, rd_step)),
        .o_rdata_b (word_r)
    );

    assign ctl_l = '{step: r_step, right: 1'b0};
    assign ctl_r = '{step: r_step, right: 1'b1};

    rmd_step u_step_l (
        .i_line (r_left),
        .i_word (word_l),
        .i_ctl  (ctl_l),
        .o_line (n_left)
    );

    rmd_step u_step_r (
        .i_line (r_right),
        .i_word (word_r),
        .i_ctl  (ctl_r),
        .o_line (n_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_step    <= '0;
            r_out_idx <= '0;
            r_end     <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_cv[i] <= rmd_pkg::INIT_CV[i];
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_s_axis_tuser[0]) begin
                            for (int i = 0; i < 5; i++) begin
                                r_cv[i] <= rmd_pkg::INIT_CV[i];
                            end
                        end
                        r_pos <= 4'(wr_addr + 4'd1);
                        r_end <= i_s_axis_tlast;
                        if (wr_addr == 4'd15) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_left  <= '{a: r_cv[0], b: r_cv[1], c: r_cv[2], d: r_cv[3], e: r_cv[4]};
                    r_right <= '{a: r_cv[0], b: r_cv[1], c: r_cv[2], d: r_cv[3], e: r_cv[4]};
                    r_step  <= '0;
                    r_state <= S_COMP;
                end
                S_COMP: begin
                    r_left  <= n_left;
                    r_right <= n_right;
                    r_step  <= 7'(r_step + 7'd1);
                    if (r_step == 7'(rmd_pkg::Steps - 1)) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_cv[0]   <= r_cv[1] + r_left.c + r_right.d;
                    r_cv[1]   <= r_cv[2] + r_left.d + r_right.e;
                    r_cv[2]   <= r_cv[3] + r_left.e + r_right.a;
                    r_cv[3]   <= r_cv[4] + r_left.a + r_right.b;
                    r_cv[4]   <= r_cv[0] + r_left.b + r_right.c;
                    r_out_idx <= '0;
                    r_state   <= r_end ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_out_idx <= 3'(r_out_idx + 3'd1);
                        if (r_out_idx == 3'd4) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while digest pending");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> (r_step < 7'(rmd_pkg::Steps)))
        else $error("step counter out of range");

    a_block_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (wr_addr == 4'd15)) |=> !o_s_axis_tready)
        else $error("ready after sixteenth word");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_m_axis_tlast) |=> (o_s_axis_tready && !o_m_axis_tvalid))
        else $error("not idle after last digest word");
`endif

endmodule
